@@ rtl/hktn_pkg.sv @@
// Package with shared constants and types, including the FNV hash constants, for the key-to-node map.
package hktn_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_CHARS   = 8;
    localparam int SLOT_COUNT  = MAX_ENTRIES * 2;
    localparam int IDX_W       = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int BYTE_W      = 4;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  TOMBSTONE = 8'd255;
    localparam logic [5:0]  COUNT_MAX = 6'd63;

    localparam logic [1:0] OP_ATTACH = 2'd0;
    localparam logic [1:0] OP_DETACH = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

endpackage

@@ rtl/hktn_hash.sv @@
// One-byte-per-cycle FNV-1a hash unit with key trimming.
module hktn_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] raw_key,
    output logic        done,
    output logic [63:0] key,
    output logic        key_empty,
    output logic [31:0] hash
);
    import hktn_pkg::*;

    logic [31:0]       hash_reg, hash_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       raw_reg, raw_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic              run_reg, run_next;
    logic [7:0]        cur_byte;

    assign cur_byte = raw_reg[7:0];

    // Consume one byte per cycle until a zero byte or the character limit.
    always_comb
    begin
        hash_next = hash_reg;
        key_next  = key_reg;
        raw_next  = raw_reg;
        pos_next  = pos_reg;
        run_next  = run_reg;
        if (load)
        begin
            hash_next = FNV_BASIS;
            key_next  = '0;
            raw_next  = raw_key;
            pos_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (cur_byte == 8'd0 || pos_reg == BYTE_W'(KEY_CHARS))
            begin
                run_next = 1'b0;
            end
            else
            begin
                hash_next = (hash_reg ^ {24'd0, cur_byte}) * FNV_PRIME;
                key_next  = key_reg | ({56'd0, cur_byte} << {pos_reg[2:0], 3'd0});
                raw_next  = raw_reg >> 8;
                pos_next  = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        key_reg  <= key_next;
        raw_reg  <= raw_next;
    end

    assign done      = !run_reg && !load;
    assign key       = key_reg;
    assign key_empty = (pos_reg == '0);
    assign hash      = hash_reg;
endmodule

@@ rtl/hashed_key_to_node_map.sv @@
// Top level of the key-to-node map: sequencer, slot table and result register.
// Each request other than evict first hashes the key one byte per cycle, then visits slots
// through a read state and a compare state on the single table port; evict sweeps all slots
// unless its node is the tombstone, and is then refused. busy is high for the whole request,
// after reset the slot valid bits clear at once, and the result appears for one cycle on
// done; the receiver cannot stall it.
module hashed_key_to_node_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [63:0] uid_key,
    input  logic [7:0]  node_id,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  node_out,
    output logic [5:0]  evicted,
    output logic [5:0]  live_count
);
    import hktn_pkg::*;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       node_reg, node_next;
    logic [7:0]       dflt_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [5:0]       count_reg, count_next;
    logic [5:0]       evict_reg, evict_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       nout_reg, nout_next;
    logic             done_reg, done_next;

    logic [63:0]      mem_key [SLOT_COUNT];
    logic [7:0]       mem_node [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [63:0]      rd_key;
    logic [7:0]       rd_node;
    logic             rd_valid;
    logic             wr_en, wr_key_en;
    logic [7:0]       wr_node;

    logic             hash_load, hash_done, key_empty;
    logic [63:0]      key;
    logic [31:0]      hash;
    logic             accept;
    logic             s_empty, s_dead, s_same;
    logic [63:0]      eff_key;
    logic [7:0]       eff_node;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    hktn_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (hash_load),
        .raw_key   (uid_key),
        .done      (hash_done),
        .key       (key),
        .key_empty (key_empty),
        .hash      (hash)
    );

    // Slot table with registered read; unwritten slots read as empty.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_node[idx_reg] <= wr_node;
            if (wr_key_en)
            begin
                mem_key[idx_reg] <= key;
            end
        end
        rd_key  <= mem_key[idx_reg];
        rd_node <= mem_node[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            rd_valid <= valid_reg[idx_reg];
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign eff_key  = rd_valid ? rd_key : 64'd0;
    assign eff_node = rd_valid ? rd_node : 8'd0;
    assign s_empty  = (eff_key == 64'd0);
    assign s_dead   = (eff_node == TOMBSTONE);
    assign s_same   = (eff_key == key);

    // Sequencer: next state, slot writes and result fields.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        node_next   = node_reg;
        idx_next    = idx_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        evict_next  = evict_reg;
        status_next = status_reg;
        nout_next   = nout_reg;
        done_next   = 1'b0;
        hash_load   = 1'b0;
        wr_en       = 1'b0;
        wr_key_en   = 1'b0;
        wr_node     = node_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    node_next   = node_id;
                    evict_next  = '0;
                    nout_next   = '0;
                    step_next   = '0;
                    status_next = ST_OK;
                    if (op == OP_EVICT)
                    begin
                        idx_next = '0;
                        if (node_id == TOMBSTONE)
                        begin
                            status_next = ST_REFUSED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        hash_load  = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    if (key_empty || (op_reg == OP_ATTACH && node_reg == TOMBSTONE))
                    begin
                        status_next = ST_REFUSED;
                        if (op_reg == OP_LOOKUP)
                        begin
                            nout_next = dflt_reg;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next    = hash[IDX_W-1:0];
                        status_next = (op_reg == OP_ATTACH) ? ST_FULL : ST_MISSING;
                        if (op_reg == OP_LOOKUP)
                        begin
                            nout_next = dflt_reg;
                        end
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_READ;
                if (op_reg == OP_EVICT)
                begin
                    if (!s_empty && eff_node == node_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_node    = TOMBSTONE;
                        evict_next = evict_reg + 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else if (op_reg == OP_ATTACH)
                begin
                    if (s_empty || s_dead || s_same)
                    begin
                        wr_en     = 1'b1;
                        wr_key_en = 1'b1;
                        if ((s_empty || s_dead) && count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    if (s_empty)
                    begin
                        state_next = S_DONE;
                    end
                    else if (!s_dead && s_same)
                    begin
                        status_next = ST_OK;
                        if (op_reg == OP_DETACH)
                        begin
                            wr_en   = 1'b1;
                            wr_node = TOMBSTONE;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            nout_next = eff_node;
                        end
                        state_next = S_DONE;
                    end
                end
                if (state_next == S_READ)
                begin
                    idx_next  = idx_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == CNT_W'(SLOT_COUNT - 1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dflt_reg  <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                dflt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        node_reg   <= node_next;
        step_reg   <= step_next;
        evict_reg  <= evict_next;
        status_reg <= status_next;
        nout_reg   <= nout_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign node_out   = nout_reg;
    assign evicted    = evict_reg;
    assign live_count = count_reg;
endmodule
